// ===== sv/cugtp_pkg.sv =====
// shared constants, types and a helper function for the color grid test pattern unit
package cugtp_pkg;

   localparam int unsigned COORD_W     = 12;
   localparam int unsigned DIM_W       = 13;
   localparam int unsigned MAX_DIM     = 4096;
   localparam logic [DIM_W-1:0] DIM_RESET = 13'd1024;

   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   // long division: 32-bit dividend, 15-bit divisor, four quotient bits per stage
   localparam int unsigned DIV_W           = 32;
   localparam int unsigned DVSR_W          = 15;
   localparam int unsigned STEPS_PER_STAGE = 4;
   localparam int unsigned NUM_DIV_STAGES  = DIV_W / STEPS_PER_STAGE;
   localparam int unsigned HUE_FRAC_W      = 16;
   localparam int unsigned VAL_SHIFT       = 17;

   localparam int unsigned NUM_COLOR_STAGES = 5;
   localparam int unsigned NUM_STAGES       = 1 + NUM_DIV_STAGES + NUM_COLOR_STAGES;

   // hue step is 2**k with k between these bounds
   localparam int unsigned STEP_LOG_MIN = 3;
   localparam int unsigned STEP_LOG_MAX = 9;

   localparam logic [15:0] V_OFFSET = 16'd6554;

   localparam int unsigned NUM_TINTS = 4;
   localparam logic [7:0] TINT_BIG   [NUM_TINTS] = '{8'd7, 8'd12, 8'd17, 8'd38};
   localparam logic [7:0] TINT_SMALL [NUM_TINTS] = '{8'd3, 8'd6, 8'd8, 8'd19};
   localparam int unsigned TINT_BIT  [NUM_TINTS] = '{0, 2, 5, 7};
   localparam int unsigned GRID_BITS = 5;
   localparam logic [7:0] GRID_ADD   = 8'd63;

   localparam int unsigned TINT_W = 8;

   typedef struct packed {
      logic [DVSR_W-1:0] rem;
      logic [DIV_W-1:0]  dq;
      logic [DVSR_W-1:0] dvsr;
   } div_lane_type;

   typedef struct packed {
      div_lane_type      hue;
      div_lane_type      val;
      logic [TINT_W-1:0] tint;
   } div_item_type;

   // restoring division, four quotient bits per call
   function automatic div_lane_type div_step4(input div_lane_type a);
      div_lane_type  r;
      logic [DVSR_W:0] rem_sh;
      r = a;
      for (int i = 0; i < STEPS_PER_STAGE; i++) begin
         rem_sh = {r.rem, r.dq[DIV_W-1]};
         r.dq   = {r.dq[DIV_W-2:0], 1'b0};
         if (rem_sh >= {1'b0, r.dvsr}) begin
            r.rem   = DVSR_W'(rem_sh - {1'b0, r.dvsr});
            r.dq[0] = 1'b1;
         end else begin
            r.rem = rem_sh[DVSR_W-1:0];
         end
      end
      return r;
   endfunction

endpackage

// ===== sv/cugtp_prep.sv =====
// input stage: dimension clamp, hue quantization, divider setup and tint sum
module cugtp_prep (
   input  logic                              clock,
   input  logic                              en,
   input  logic [cugtp_pkg::COORD_W-1:0]     col,
   input  logic [cugtp_pkg::COORD_W-1:0]     row,
   input  logic [cugtp_pkg::DIM_W-1:0]       image_width,
   input  logic [cugtp_pkg::DIM_W-1:0]       image_height,
   output cugtp_pkg::div_item_type           item
);
   import cugtp_pkg::*;

   logic [DIM_W-1:0]   width_c;
   logic [DIM_W-1:0]   height_c;
   logic [DIM_W-4:0]   width_div8;
   logic [COORD_W-1:0] low_mask;
   logic [COORD_W-1:0] q;
   logic [TINT_W-1:0]  tint;
   div_item_type       item_in;
   div_item_type       item_ff;

   always_comb begin
      width_c = image_width;
      if (image_width == '0) begin
         width_c = DIM_W'(1);
      end else if (image_width > DIM_W'(MAX_DIM)) begin
         width_c = DIM_W'(MAX_DIM);
      end
      height_c = image_height;
      if (image_height == '0) begin
         height_c = DIM_W'(1);
      end else if (image_height > DIM_W'(MAX_DIM)) begin
         height_c = DIM_W'(MAX_DIM);
      end
   end

   // step is the smallest power of two at or above width/8, at least 8
   always_comb begin
      width_div8 = width_c[DIM_W-1:3];
      low_mask   = COORD_W'((1 << STEP_LOG_MIN) - 1);
      for (int k = STEP_LOG_MIN + 1; k <= STEP_LOG_MAX; k++) begin
         if (width_div8 > (DIM_W-3)'(1 << (k - 1))) begin
            low_mask = COORD_W'((1 << k) - 1);
         end
      end
      q = col & ~low_mask;
   end

   // all tints and the grid add saturate at 255, so one summed add is the same
   always_comb begin
      tint = '0;
      for (int t = 0; t < NUM_TINTS; t++) begin
         if (col[TINT_BIT[t]] == row[TINT_BIT[t]]) begin
            tint = tint + TINT_BIG[t];
         end else begin
            tint = tint + TINT_SMALL[t];
         end
      end
      if (col[GRID_BITS-1:0] == '0 || row[GRID_BITS-1:0] == '0) begin
         tint = tint + GRID_ADD;
      end
   end

   always_comb begin
      item_in.hue.rem  = '0;
      item_in.hue.dq   = {{(DIV_W-COORD_W-HUE_FRAC_W){1'b0}}, q, {HUE_FRAC_W{1'b0}}};
      item_in.hue.dvsr = DVSR_W'(width_c);
      item_in.val.rem  = '0;
      item_in.val.dq   = {{(DIV_W-COORD_W-VAL_SHIFT){1'b0}}, row, {VAL_SHIFT{1'b0}}};
      item_in.val.dvsr = DVSR_W'({height_c, 2'b00}) + DVSR_W'(height_c);
      item_in.tint     = tint;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign item = item_ff;

endmodule

// ===== sv/cugtp_div_stage.sv =====
// one divider stage: four restoring steps on both the hue and value quotients
module cugtp_div_stage (
   input  logic                    clock,
   input  logic                    en,
   input  cugtp_pkg::div_item_type item_in,
   output cugtp_pkg::div_item_type item_out
);
   import cugtp_pkg::*;

   div_item_type item_in_c;
   div_item_type item_ff;

   always_comb begin
      item_in_c.hue  = div_step4(item_in.hue);
      item_in_c.val  = div_step4(item_in.val);
      item_in_c.tint = item_in.tint;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in_c;
      end
   end

   assign item_out = item_ff;

endmodule

// ===== sv/cugtp_color.sv =====
// hsv to rgb back end: hue ramps, value scaling, byte conversion, tint add
module cugtp_color (
   input  logic                                    clock,
   input  logic [cugtp_pkg::NUM_COLOR_STAGES-1:0]  en,
   input  cugtp_pkg::div_item_type                 item_in,
   output logic [7:0]                              red,
   output logic [7:0]                              green,
   output logic [7:0]                              blue
);
   import cugtp_pkg::*;

   // stage 0: hue times six, value with offset
   logic [15:0]       h16;
   logic [16:0]       v_sum;
   logic [18:0]       h6_in;
   logic [15:0]       v_in;
   logic [18:0]       h6_ff;
   logic [15:0]       v0_ff;
   logic [TINT_W-1:0] tint0_ff;

   // stage 1: ramps
   logic signed [20:0] hs;
   logic signed [20:0] dr, dg, db;
   logic signed [20:0] ar, ag, ab;
   logic [16:0]        ramp_in [3];
   logic [16:0]        ramp_ff [3];
   logic [15:0]        v1_ff;
   logic [TINT_W-1:0]  tint1_ff;

   // stage 2: ramp times value
   logic [32:0]        prod_ff [3];
   logic [TINT_W-1:0]  tint2_ff;

   // stage 3: times 255, top byte
   logic [40:0]        p255 [3];
   logic [7:0]         byte_ff [3];
   logic [TINT_W-1:0]  tint3_ff;

   // stage 4: saturating tint add
   logic [8:0]         sum9 [3];
   logic [7:0]         pix_in [3];
   logic [7:0]         pix_ff [3];

   function automatic logic [16:0] ramp_clamp(input logic signed [20:0] c);
      logic [16:0] r;
      if (c < 21'sd0) begin
         r = '0;
      end else if (c > 21'sd65536) begin
         r = 17'h10000;
      end else begin
         r = c[16:0];
      end
      return r;
   endfunction

   always_comb begin
      h16   = item_in.hue.dq[15:0];
      h6_in = 19'({h16, 2'b00}) + 19'({h16, 1'b0});
      v_sum = {1'b0, item_in.val.dq[15:0]} + {1'b0, V_OFFSET};
      if (item_in.val.dq[DIV_W-1:16] != '0 || v_sum[16]) begin
         v_in = 16'hFFFF;
      end else begin
         v_in = v_sum[15:0];
      end
   end

   always_comb begin
      hs = signed'({2'b00, h6_ff});
      dr = hs - 21'sd196608;
      dg = hs - 21'sd131072;
      db = hs - 21'sd262144;
      ar = (dr < 21'sd0) ? -dr : dr;
      ag = (dg < 21'sd0) ? -dg : dg;
      ab = (db < 21'sd0) ? -db : db;
      ramp_in[0] = ramp_clamp(ar - 21'sd65536);
      ramp_in[1] = ramp_clamp(21'sd131072 - ag);
      ramp_in[2] = ramp_clamp(21'sd131072 - ab);
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         // p * 255 = (p << 8) - p
         p255[c] = {prod_ff[c], 8'b0} - {8'b0, prod_ff[c]};
         sum9[c] = {1'b0, byte_ff[c]} + {1'b0, tint3_ff};
         pix_in[c] = sum9[c][8] ? 8'hFF : sum9[c][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         h6_ff    <= h6_in;
         v0_ff    <= v_in;
         tint0_ff <= item_in.tint;
      end
      if (en[1]) begin
         ramp_ff  <= ramp_in;
         v1_ff    <= v0_ff;
         tint1_ff <= tint0_ff;
      end
      if (en[2]) begin
         for (int c = 0; c < 3; c++) begin
            prod_ff[c] <= 33'(ramp_ff[c]) * 33'(v1_ff);
         end
         tint2_ff <= tint1_ff;
      end
      if (en[3]) begin
         for (int c = 0; c < 3; c++) begin
            byte_ff[c] <= p255[c][39:32];
         end
         tint3_ff <= tint2_ff;
      end
      if (en[4]) begin
         pix_ff <= pix_in;
      end
   end

   assign red   = pix_ff[0];
   assign green = pix_ff[1];
   assign blue  = pix_ff[2];

endmodule

// ===== sv/color_uv_grid_test_pattern_unit.sv =====
// top level of the color grid test pattern unit: registers, pipeline control
//
//   port group  direction  transfer when             contents
//   req_*       in         req_valid & req_ready     col, row
//   rsp_*       out        rsp_valid & rsp_ready     red, green, blue
//   csr_*       in/out     psel & penable & pwrite   image_width (0x0), image_height (0x4)
//
// one pixel per cycle while the output is not stalled
// the pipeline depth comes mostly from the 32-step long divisions, four steps in each of eight stages
// every stage carries a valid bit; a stage takes new data when it is empty or moving
// a stall at the output fills empty stages first, nothing is dropped or repeated
// synchronous reset clears the valid bits and loads 1024 into both registers
module color_uv_grid_test_pattern_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [cugtp_pkg::COORD_W-1:0]      req_col,
   input  logic [cugtp_pkg::COORD_W-1:0]      req_row,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_red,
   output logic [7:0]                         rsp_green,
   output logic [7:0]                         rsp_blue,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cugtp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cugtp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cugtp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready
);
   import cugtp_pkg::*;

   logic [DIM_W-1:0]      width_ff, width_in;
   logic [DIM_W-1:0]      height_ff, height_in;
   logic                  csr_wr;
   reg_index_type         csr_index;

   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic [NUM_STAGES-1:0] rdy;

   div_item_type          div_chain [NUM_DIV_STAGES+1];

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         unique case (csr_index)
            REG_WIDTH:  width_in  = csr_pwdata[DIM_W-1:0];
            REG_HEIGHT: height_in = csr_pwdata[DIM_W-1:0];
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // pipeline control: a stage loads when it is empty or the next one loads
   assign rdy[NUM_STAGES-1] = ~vld_ff[NUM_STAGES-1] | rsp_ready;
   for (genvar i = 0; i < NUM_STAGES - 1; i++) begin : g_rdy
      assign rdy[i] = ~vld_ff[i] | rdy[i+1];
   end

   always_comb begin
      vld_in[0] = rdy[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         vld_in[i] = rdy[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   // datapath
   cugtp_prep u_prep (
      .clock        (clock),
      .en           (rdy[0]),
      .col          (req_col),
      .row          (req_row),
      .image_width  (width_ff),
      .image_height (height_ff),
      .item         (div_chain[0])
   );

   for (genvar g = 0; g < NUM_DIV_STAGES; g++) begin : g_div
      cugtp_div_stage u_div_stage (
         .clock    (clock),
         .en       (rdy[1+g]),
         .item_in  (div_chain[g]),
         .item_out (div_chain[g+1])
      );
   end

   cugtp_color u_color (
      .clock   (clock),
      .en      (rdy[NUM_STAGES-1:1+NUM_DIV_STAGES]),
      .item_in (div_chain[NUM_DIV_STAGES]),
      .red     (rsp_red),
      .green   (rsp_green),
      .blue    (rsp_blue)
   );

endmodule

// ===== sv/cugtp_checker.sv =====
// port-level checker for the color grid test pattern unit, bound to the top level
module cugtp_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_ready,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [7:0]                         rsp_red,
   input  logic [7:0]                         rsp_green,
   input  logic [7:0]                         rsp_blue,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cugtp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cugtp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  logic [cugtp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input  logic                               csr_pready
);
   import cugtp_pkg::*;

   logic csr_wr;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // a stalled result keeps its valid and its pixel
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
         && $stable(rsp_blue))
      else $error("stalled result changed");

   // with the output stage empty the whole pipeline can take an item
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output stage empty");

   // reset empties the output stage and restores the dimension that the address selects
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && csr_prdata == CSR_DATA_W'(DIM_RESET))
      else $error("wrong state after reset");

   // a written register reads back its value in the next cycle
   a_readback: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> (csr_paddr[2] != $past(csr_paddr[2]))
         || (csr_prdata == CSR_DATA_W'($past(csr_pwdata[DIM_W-1:0]))))
      else $error("register readback mismatch");

endmodule

bind color_uv_grid_test_pattern_unit cugtp_checker u_cugtp_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the color grid test pattern unit
module testbench;
   import cugtp_pkg::*;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } pixel_pos_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_rgb_type;

   // checker tints: bit of col/row that gives the parity, amount when parities match or differ
   localparam logic [3:0][2:0] CHECKER_SHIFT = {3'd7, 3'd5, 3'd2, 3'd0};
   localparam logic [3:0][7:0] CHECKER_SAME  = {8'd38, 8'd17, 8'd12, 8'd7};
   localparam logic [3:0][7:0] CHECKER_DIFF  = {8'd19, 8'd8, 8'd6, 8'd3};
   localparam int unsigned GRID_LINE_ADD     = 63;
   localparam int unsigned DIM_LIMIT         = 4096;
   localparam logic [DIM_W-1:0] SIZE_AT_RESET = 13'd1024;

   localparam int unsigned PHASE_COUNT       = 10;
   localparam int unsigned PIXELS_PER_PHASE  = 70;
   localparam int unsigned DRAIN_CYCLES      = 40;

   localparam logic [7:0][DIM_W-1:0] PHASE_WIDTH = {
      13'd64, 13'd4095, 13'd1920, 13'd640, 13'd8191, 13'd0, 13'd4096, 13'd1};
   localparam logic [7:0][DIM_W-1:0] PHASE_HEIGHT = {
      13'd4096, 13'd2, 13'd1080, 13'd480, 13'd6000, 13'd0, 13'd4096, 13'd1};

   // corners, wrap past the width, grid lines, checker edges and hue sector boundaries
   localparam int unsigned DIRECTED_COUNT = 21;
   localparam logic [20:0][23:0] DIRECTED_PIXELS = {
      {12'd0, 12'd0},       {12'd4095, 12'd4095}, {12'd0, 12'd4095},
      {12'd4095, 12'd0},    {12'd1023, 12'd1023}, {12'd1024, 12'd512},
      {12'd2047, 12'd1500}, {12'd31, 12'd31},     {12'd32, 12'd32},
      {12'd33, 12'd1},      {12'd127, 12'd127},   {12'd128, 12'd128},
      {12'd129, 12'd255},   {12'd170, 12'd300},   {12'd341, 12'd600},
      {12'd512, 12'd700},   {12'd683, 12'd800},   {12'd853, 12'd900},
      {12'd960, 12'd1024},  {12'd2730, 12'd3},    {12'd3, 12'd2}};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [COORD_W-1:0]    req_col = '0;
   logic [COORD_W-1:0]    req_row = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_red;
   logic [7:0]            rsp_green;
   logic [7:0]            rsp_blue;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [DIM_W-1:0] cfg_width = SIZE_AT_RESET;
   logic [DIM_W-1:0] cfg_height = SIZE_AT_RESET;

   pixel_pos_type  pixel_queue [$];
   pixel_rgb_type  expected_colors [$];
   pixel_pos_type  next_pos;
   pixel_rgb_type  expected_px;
   bit          idle_enable = 1'b1;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned outstanding = 0;
   int unsigned accepted = 0;
   int unsigned checked = 0;
   int unsigned csr_writes = 0;
   int unsigned errors = 0;

   color_uv_grid_test_pattern_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned pause_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic longint unsigned clamp_dimension(input logic [DIM_W-1:0] d);
      if (d == 0) return 1;
      if (d > DIM_LIMIT) return DIM_LIMIT;
      return 64'(d);
   endfunction

   function automatic longint ramp_limit(input longint c);
      if (c < 0) return 0;
      if (c > 65536) return 65536;
      return c;
   endfunction

   function automatic longint distance(input longint a, input longint b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic int unsigned sat_byte(input int unsigned s);
      return (s > 255) ? 255 : s;
   endfunction

   // hsv base color in q0.16, then checker tints and grid lines, all saturating
   function automatic pixel_rgb_type grid_pixel(input logic [COORD_W-1:0] col,
                                                input logic [COORD_W-1:0] row);
      longint unsigned w, hgt, step, hue, val;
      longint          h6;
      longint          ramp [3];
      int unsigned     chan [3];
      int unsigned     bump;
      int              t, c;
      pixel_rgb_type   px;
      w = clamp_dimension(cfg_width);
      hgt = clamp_dimension(cfg_height);
      step = 1;
      while (step < w / 8) step = step << 1;
      if (step < 8) step = 8;
      hue = ((((64'(col) / step) * step) << 16) / w) & 64'hFFFF;
      val = 6554 + (64'(row) * 131072) / (hgt * 5);
      if (val > 65535) val = 65535;
      h6 = 6 * longint'(hue);
      ramp[0] = ramp_limit(distance(h6, 196608) - 65536);
      ramp[1] = ramp_limit(131072 - distance(h6, 131072));
      ramp[2] = ramp_limit(131072 - distance(h6, 262144));
      for (c = 0; c < 3; c++) chan[c] = 32'((64'(ramp[c]) * val * 255) >> 32);
      for (t = 0; t < 4; t++) begin
         bump = (col[CHECKER_SHIFT[t]] == row[CHECKER_SHIFT[t]]) ? 32'(CHECKER_SAME[t])
                                                                : 32'(CHECKER_DIFF[t]);
         for (c = 0; c < 3; c++) chan[c] = sat_byte(chan[c] + bump);
      end
      if (col[4:0] == 0 || row[4:0] == 0) begin
         for (c = 0; c < 3; c++) chan[c] = sat_byte(chan[c] + GRID_LINE_ADD);
      end
      px.red = 8'(chan[0]);
      px.green = 8'(chan[1]);
      px.blue = 8'(chan[2]);
      return px;
   endfunction

   task automatic check_byte(input string field, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   // input side: one pixel per transfer, random gaps after each while idle_enable is set
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_colors.push_back(grid_pixel(req_col, req_row));
            accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
               req_col <= COORD_W'($urandom);
               req_row <= COORD_W'($urandom);
            end else if (pixel_queue.size() > 0) begin
               next_pos = pixel_queue.pop_front();
               req_valid <= 1'b1;
               req_col <= next_pos.col;
               req_row <= next_pos.row;
               if (idle_enable) gap_left = pause_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side: compare each transfer against the oldest predicted pixel
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_colors.size() == 0) begin
               errors++;
               $display("%0t: unexpected pixel, expected none, got %0d %0d %0d",
                        $time, rsp_red, rsp_green, rsp_blue);
            end else begin
               expected_px = expected_colors.pop_front();
               check_byte("red", expected_px.red, rsp_red);
               check_byte("green", expected_px.green, rsp_green);
               check_byte("blue", expected_px.blue, rsp_blue);
               checked++;
               outstanding--;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_enable && ((rsp_valid && rsp_ready) || $urandom_range(0, 7) == 0))
               stall_left = pause_length();
         end
      end
   end

   task automatic queue_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
      pixel_pos_type pos;
      pos.col = col;
      pos.row = row;
      pixel_queue.push_back(pos);
      outstanding++;
   endtask

   task automatic wait_drained();
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic csr_transfer(input logic wr, input reg_index_type idx,
                               input logic [CSR_DATA_W-1:0] wdata,
                               output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic check_register(input reg_index_type idx);
      logic [CSR_DATA_W-1:0] rdata;
      logic [CSR_DATA_W-1:0] want;
      want = {19'd0, (idx == REG_WIDTH) ? cfg_width : cfg_height};
      csr_transfer(1'b0, idx, '0, rdata);
      if (rdata !== want) begin
         errors++;
         $display("%0t: register %s readback, expected %0d, got %0d",
                  $time, idx.name(), want, rdata);
      end
   endtask

   // upper data bits are random; only the low 13 are kept
   task automatic set_register(input reg_index_type idx, input logic [DIM_W-1:0] value);
      logic [CSR_DATA_W-1:0] rdata;
      csr_transfer(1'b1, idx, {19'($urandom), value}, rdata);
      if (idx == REG_WIDTH) cfg_width = value;
      else cfg_height = value;
      csr_writes++;
      check_register(idx);
   endtask

   initial begin
      int unsigned p, k, run, pick, queued, lim_w, lim_h, start_col, start_row;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      check_register(REG_WIDTH);
      check_register(REG_HEIGHT);
      for (k = 0; k < DIRECTED_COUNT; k++)
         queue_pixel(DIRECTED_PIXELS[k][23:12], DIRECTED_PIXELS[k][11:0]);
      wait_drained();

      for (p = 0; p < PHASE_COUNT; p++) begin
         idle_enable = (p % 4) != 2;
         if (p < 8) begin
            set_register(REG_WIDTH, PHASE_WIDTH[p]);
            set_register(REG_HEIGHT, PHASE_HEIGHT[p]);
         end else begin
            set_register(REG_WIDTH, DIM_W'($urandom_range(1, DIM_LIMIT)));
            set_register(REG_HEIGHT, DIM_W'($urandom_range(0, 8191)));
         end
         lim_w = 32'(clamp_dimension(cfg_width));
         lim_h = 32'(clamp_dimension(cfg_height));
         queued = 0;
         while (queued < PIXELS_PER_PHASE) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               // short raster run starting inside the image
               run = $urandom_range(1, 16);
               start_col = $urandom_range(0, lim_w - 1);
               start_row = $urandom_range(0, lim_h - 1);
               for (k = 0; k < run; k++)
                  queue_pixel(COORD_W'(start_col + k), COORD_W'(start_row));
               queued += run;
            end else if (pick < 8) begin
               queue_pixel(COORD_W'($urandom_range(0, lim_w - 1)),
                           COORD_W'($urandom_range(0, lim_h - 1)));
               queued++;
            end else begin
               queue_pixel(COORD_W'($urandom), COORD_W'($urandom));
               queued++;
            end
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_colors.size() != 0) begin
         errors++;
         $display("%0t: %0d pixels never came out", $time, expected_colors.size());
      end
      $display("covered %0d pixels (%0d checked) over %0d size settings, %0d register writes",
               accepted, checked, PHASE_COUNT + 1, csr_writes);
      $display("sizes included zero, oversize and both limits; %0d mismatches", errors);
      if (errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout with %0d pixels outstanding", $time, outstanding);
      $display("testbench failed");
      $finish;
   end

endmodule

// ===== files.f =====
sv/cugtp_pkg.sv
sv/cugtp_prep.sv
sv/cugtp_div_stage.sv
sv/cugtp_color.sv
sv/color_uv_grid_test_pattern_unit.sv
sv/cugtp_checker.sv
tb/testbench.sv
